@@ src/modbus_rtu_slave_engine_defines.svh @@
// Assertion macros used by the checker of the Modbus RTU slave engine.
// Depends on nothing; included by the checker module.
`ifndef MODBUS_RTU_SLAVE_ENGINE_DEFINES_SVH
`define MODBUS_RTU_SLAVE_ENGINE_DEFINES_SVH

// Property checked on each rising edge, switched off while reset is asserted.
`define MRS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on each rising edge, reset included.
`define MRS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/mrs_pkg.sv @@
// Types and constants of the Modbus RTU slave engine.
// No dependencies; used by the engine and the checker of the block.
package mrs_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  rx_byte;
        logic        frame_end;
        logic [5:0]  point_index;
        logic [15:0] point_value;
    } t_in_item;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] tx_byte;
        logic       last;
        logic [2:0] frame_status;
    } t_out_item;

    localparam logic [1:0] OP_RX_BYTE   = 2'd0;
    localparam logic [1:0] OP_SET_DISC  = 2'd1;
    localparam logic [1:0] OP_SET_INREG = 2'd2;

    localparam logic [2:0] ST_REPLY     = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_OTHER     = 3'd2;
    localparam logic [2:0] ST_CRC_ERR   = 3'd3;
    localparam logic [2:0] ST_BROADCAST = 3'd4;

    localparam logic [7:0] FC_RD_COILS    = 8'd1;
    localparam logic [7:0] FC_RD_DISC     = 8'd2;
    localparam logic [7:0] FC_RD_HOLDING  = 8'd3;
    localparam logic [7:0] FC_RD_INPUT    = 8'd4;
    localparam logic [7:0] FC_WR_COIL     = 8'd5;
    localparam logic [7:0] FC_WR_REG      = 8'd6;
    localparam logic [7:0] FC_WR_COILS    = 8'd15;
    localparam logic [7:0] FC_WR_REGS     = 8'd16;
    localparam logic [7:0] FC_RD_FIFO     = 8'd24;

    localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'd1;
    localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'd2;
    localparam logic [7:0] EXC_ILLEGAL_DATA = 8'd3;
    localparam logic [7:0] EXC_FLAG         = 8'h80;

    localparam logic [15:0] COIL_ON  = 16'hFF00;
    localparam logic [15:0] COIL_OFF = 16'h0000;

    localparam logic [6:0] FRAME_DEPTH = 7'd64;
    localparam logic [6:0] COUNT_MAX   = 7'd127;
    localparam logic [6:0] MIN_FRAME   = 7'd3;

    localparam logic [2:0] CFG_SLAVE_ADDR = 3'd0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_CRC,
        S_CRC_LO,
        S_CRC_HI,
        S_HDR,
        S_DECIDE,
        S_WR_COILS,
        S_WR_REGS,
        S_HEAD,
        S_BITS,
        S_REGS,
        S_TX_LO,
        S_TX_HI,
        S_STATUS
    } t_state;

    typedef enum logic [1:0] {
        K_EXC,
        K_ECHO,
        K_BITS,
        K_REGS
    } t_kind;

endpackage

@@ src/mrs_crc16.sv @@
// Shared CRC-16/MODBUS register, one byte per cycle.
// Depends on nothing; used by the engine for request checking and reply generation.
module mrs_crc16 (
    input  logic        i_clk,
    input  logic        i_init,
    input  logic        i_en,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc ^ {8'h00, i_data};
        for (int b = 0; b < 8; b++) begin
            n_crc = n_crc[0] ? ((n_crc >> 1) ^ 16'hA001) : (n_crc >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_crc <= 16'hFFFF;
        end else if (i_en) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

@@ src/modbus_rtu_slave_engine.sv @@
// Modbus RTU slave engine. A byte or point update is taken while idle; a closing byte starts
// the address check, the CRC pass over the request, header decode and then the writes and
// the reply or a status result, with busy high throughout. One shared CRC unit and one
// read port per store serve all of these steps. Results cannot be held off by the receiver.
// After reset a clearing pass zeroes the point stores, busy high.
// Depends on mrs_pkg and mrs_crc16.
module modbus_rtu_slave_engine #(
    parameter int NUM_COILS      = 64,
    parameter int NUM_DISCRETE   = 64,
    parameter int NUM_HOLDING    = 64,
    parameter int NUM_INPUT_REGS = 64,
    parameter int MAX_BIT_COUNT  = 128,
    parameter int MAX_REG_COUNT  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  mrs_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output mrs_pkg::t_out_item o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int MAXD1 = (NUM_COILS > NUM_DISCRETE) ? NUM_COILS : NUM_DISCRETE;
    localparam int MAXD2 = (NUM_HOLDING > NUM_INPUT_REGS) ? NUM_HOLDING : NUM_INPUT_REGS;
    localparam int MAXD  = (MAXD1 > MAXD2) ? MAXD1 : MAXD2;
    localparam int AWC   = $clog2(NUM_COILS);
    localparam int AWD   = $clog2(NUM_DISCRETE);
    localparam int AWH   = $clog2(NUM_HOLDING);
    localparam int AWI   = $clog2(NUM_INPUT_REGS);
    localparam int PW    = $clog2(MAXD);
    localparam int IW    = $clog2(MAX_BIT_COUNT + 2 * MAX_REG_COUNT + 8);

    mrs_pkg::t_state r_state, n_state;
    mrs_pkg::t_kind  r_kind, n_kind;

    logic [7:0]    r_slave;
    logic [6:0]    r_cnt, n_cnt;
    logic [6:0]    r_n, n_n;
    logic [6:0]    r_fidx, n_fidx;
    logic [7:0]    r_frd;
    logic [7:0]    r_a, n_a;
    logic [7:0]    r_fc, n_fc;
    logic [15:0]   r_start, n_start;
    logic [15:0]   r_qty, n_qty;
    logic [7:0]    r_bc, n_bc;
    logic [7:0]    r_exc, n_exc;
    logic          r_bcast, n_bcast;
    logic [2:0]    r_status, n_status;
    logic [2:0]    r_k, n_k;
    logic [IW-1:0] r_i, n_i;
    logic [IW-1:0] r_end, n_end;
    logic [PW-1:0] r_pa, n_pa;
    logic [7:0]    r_acc, n_acc;
    logic [7:0]    r_bcnt, n_bcnt;
    logic [PW-1:0] r_clr, n_clr;

    logic [7:0]  frame_mem [64];
    logic        coil_mem  [NUM_COILS];
    logic        disc_mem  [NUM_DISCRETE];
    logic [15:0] hold_mem  [NUM_HOLDING];
    logic [15:0] inp_mem   [NUM_INPUT_REGS];

    logic        r_coil_rd, r_disc_rd;
    logic [15:0] r_hold_rd, r_inp_rd;

    logic            accept;
    logic            frame_we;
    logic            coil_we, disc_we, hold_we, inp_we;
    logic [AWC-1:0]  coil_wa;
    logic [AWD-1:0]  disc_wa;
    logic [AWH-1:0]  hold_wa;
    logic [AWI-1:0]  inp_wa;
    logic            coil_wd, disc_wd;
    logic [15:0]     hold_wd, inp_wd;

    logic        crc_init, crc_en;
    logic [7:0]  crc_data;
    logic [15:0] crc;

    logic [7:0]  fb;
    logic [16:0] sq;
    logic [16:0] nb;
    logic [16:0] q2;
    logic [7:0]  head_byte;
    logic        bit_v;
    logic [7:0]  acc_nx;
    logic [15:0] word_v;
    logic [6:0]  cnt_inc;

    mrs_crc16 u_crc (
        .i_clk  (i_clk),
        .i_init (crc_init),
        .i_en   (crc_en),
        .i_data (crc_data),
        .o_crc  (crc)
    );

    assign accept = start && !busy;
    assign busy   = (r_state != mrs_pkg::S_IDLE);
    assign pready = 1'b1;
    assign prdata = (paddr == mrs_pkg::CFG_SLAVE_ADDR) ? {24'h000000, r_slave} : 32'h0;

    // A request field past the received length reads as zero.
    assign fb  = (r_fidx < r_n) ? r_frd : 8'h00;
    assign sq  = {1'b0, r_start} + {1'b0, r_qty};
    assign nb  = ({1'b0, r_qty} + 17'd7) >> 3;
    assign q2  = {r_qty, 1'b0};
    assign cnt_inc = (r_cnt < mrs_pkg::COUNT_MAX) ? r_cnt + 7'd1 : r_cnt;

    always_comb begin
        case (r_k)
            3'd0:    head_byte = r_a;
            3'd1:    head_byte = (r_kind == mrs_pkg::K_EXC) ? (r_fc + mrs_pkg::EXC_FLAG) : r_fc;
            3'd2:    head_byte = (r_kind == mrs_pkg::K_EXC)  ? r_exc :
                                 (r_kind == mrs_pkg::K_ECHO) ? r_start[15:8] : r_bcnt;
            3'd3:    head_byte = r_start[7:0];
            3'd4:    head_byte = r_qty[15:8];
            default: head_byte = r_qty[7:0];
        endcase
    end

    assign bit_v  = (32'(r_i) < 32'(r_qty)) &&
                    ((r_fc == mrs_pkg::FC_RD_COILS) ? r_coil_rd : r_disc_rd);
    assign acc_nx = ((r_i[2:0] == 3'd0) ? 8'h00 : r_acc) | (8'(bit_v) << r_i[2:0]);
    assign word_v = (r_fc == mrs_pkg::FC_RD_HOLDING) ? r_hold_rd : r_inp_rd;

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_cnt    = r_cnt;
        n_n      = r_n;
        n_fidx   = r_fidx;
        n_a      = r_a;
        n_fc     = r_fc;
        n_start  = r_start;
        n_qty    = r_qty;
        n_bc     = r_bc;
        n_exc    = r_exc;
        n_bcast  = r_bcast;
        n_status = r_status;
        n_k      = r_k;
        n_i      = r_i;
        n_end    = r_end;
        n_pa     = r_pa;
        n_acc    = r_acc;
        n_bcnt   = r_bcnt;
        n_clr    = r_clr;
        frame_we = 1'b0;
        coil_we  = 1'b0;
        disc_we  = 1'b0;
        hold_we  = 1'b0;
        inp_we   = 1'b0;
        coil_wa  = AWC'(r_pa);
        disc_wa  = AWD'(i_item.point_index);
        hold_wa  = AWH'(r_pa);
        inp_wa   = AWI'(i_item.point_index);
        coil_wd  = 1'b0;
        disc_wd  = i_item.point_value[0];
        hold_wd  = 16'h0;
        inp_wd   = i_item.point_value;
        crc_init = 1'b0;
        crc_en   = 1'b0;
        crc_data = fb;
        o_strobe = 1'b0;
        o_result = '0;

        unique case (r_state)
            mrs_pkg::S_CLEAR: begin
                coil_we = (32'(r_clr) < NUM_COILS);
                disc_we = (32'(r_clr) < NUM_DISCRETE);
                hold_we = (32'(r_clr) < NUM_HOLDING);
                inp_we  = (32'(r_clr) < NUM_INPUT_REGS);
                coil_wa = AWC'(r_clr);
                disc_wa = AWD'(r_clr);
                hold_wa = AWH'(r_clr);
                inp_wa  = AWI'(r_clr);
                disc_wd = 1'b0;
                inp_wd  = 16'h0;
                if (r_clr == PW'(MAXD - 1)) begin
                    n_state = mrs_pkg::S_IDLE;
                end else begin
                    n_clr = r_clr + PW'(1);
                end
            end
            mrs_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_item.operation)
                        mrs_pkg::OP_RX_BYTE: begin
                            frame_we = (r_cnt < mrs_pkg::FRAME_DEPTH);
                            n_cnt    = cnt_inc;
                            if (i_item.frame_end) begin
                                n_cnt  = 7'd0;
                                n_n    = cnt_inc;
                                n_fidx = 7'd0;
                                if (cnt_inc < mrs_pkg::MIN_FRAME) begin
                                    n_status = mrs_pkg::ST_SHORT;
                                    n_state  = mrs_pkg::S_STATUS;
                                end else begin
                                    n_state = mrs_pkg::S_ADDR;
                                end
                            end
                        end
                        mrs_pkg::OP_SET_DISC: begin
                            disc_we = (32'(i_item.point_index) < NUM_DISCRETE);
                        end
                        mrs_pkg::OP_SET_INREG: begin
                            inp_we = (32'(i_item.point_index) < NUM_INPUT_REGS);
                        end
                        default: ;
                    endcase
                end
            end
            mrs_pkg::S_ADDR: begin
                n_a = fb;
                if (fb != r_slave && fb != 8'h00) begin
                    n_status = mrs_pkg::ST_OTHER;
                    n_state  = mrs_pkg::S_STATUS;
                end else if (r_n > mrs_pkg::FRAME_DEPTH) begin
                    n_status = mrs_pkg::ST_CRC_ERR;
                    n_state  = mrs_pkg::S_STATUS;
                end else begin
                    crc_init = 1'b1;
                    n_state  = mrs_pkg::S_CRC;
                end
            end
            mrs_pkg::S_CRC: begin
                crc_en = 1'b1;
                if (r_fidx == r_n - 7'd3) begin
                    n_fidx  = r_n - 7'd2;
                    n_state = mrs_pkg::S_CRC_LO;
                end else begin
                    n_fidx = r_fidx + 7'd1;
                end
            end
            mrs_pkg::S_CRC_LO: begin
                if (fb != crc[7:0]) begin
                    n_status = mrs_pkg::ST_CRC_ERR;
                    n_state  = mrs_pkg::S_STATUS;
                end else begin
                    n_fidx  = r_n - 7'd1;
                    n_state = mrs_pkg::S_CRC_HI;
                end
            end
            mrs_pkg::S_CRC_HI: begin
                if (fb != crc[15:8]) begin
                    n_status = mrs_pkg::ST_CRC_ERR;
                    n_state  = mrs_pkg::S_STATUS;
                end else begin
                    n_fidx  = 7'd1;
                    n_state = mrs_pkg::S_HDR;
                end
            end
            mrs_pkg::S_HDR: begin
                n_fidx = r_fidx + 7'd1;
                case (r_fidx[2:0])
                    3'd1:    n_fc = fb;
                    3'd2:    n_start[15:8] = fb;
                    3'd3:    n_start[7:0] = fb;
                    3'd4:    n_qty[15:8] = fb;
                    3'd5:    n_qty[7:0] = fb;
                    default: begin
                        n_bc    = fb;
                        n_state = mrs_pkg::S_DECIDE;
                    end
                endcase
            end
            mrs_pkg::S_DECIDE: begin
                n_k    = 3'd0;
                n_i    = '0;
                n_pa   = PW'(r_start);
                n_fidx = 7'd7;
                n_bcast = (r_a != r_slave);
                if (r_a != r_slave) begin
                    // Broadcast: only holding register writes, never a reply.
                    n_status = mrs_pkg::ST_BROADCAST;
                    n_state  = mrs_pkg::S_STATUS;
                    if (r_fc == mrs_pkg::FC_WR_REG) begin
                        hold_we = (32'(r_start) < NUM_HOLDING);
                        hold_wa = AWH'(r_start);
                        hold_wd = r_qty;
                    end else if (r_fc == mrs_pkg::FC_WR_REGS) begin
                        n_end = IW'(q2 - 17'd1);
                        if (!(32'(r_qty) + 1 > MAX_REG_COUNT || {9'h0, r_bc} != q2) &&
                            !(32'(sq) > NUM_HOLDING) && r_qty != 16'h0) begin
                            n_state = mrs_pkg::S_WR_REGS;
                        end
                    end
                end else begin
                    crc_init = 1'b1;
                    n_state  = mrs_pkg::S_HEAD;
                    n_kind   = mrs_pkg::K_EXC;
                    case (r_fc)
                        mrs_pkg::FC_RD_COILS, mrs_pkg::FC_RD_DISC: begin
                            n_bcnt = 8'(nb);
                            n_end  = IW'({nb, 3'b000} - 20'd1);
                            if (32'(r_qty) > MAX_BIT_COUNT) begin
                                n_exc = mrs_pkg::EXC_ILLEGAL_DATA;
                            end else if (32'(sq) > ((r_fc == mrs_pkg::FC_RD_COILS) ?
                                                    NUM_COILS : NUM_DISCRETE)) begin
                                n_exc = mrs_pkg::EXC_ILLEGAL_ADDR;
                            end else begin
                                n_kind = mrs_pkg::K_BITS;
                            end
                        end
                        mrs_pkg::FC_RD_HOLDING, mrs_pkg::FC_RD_INPUT: begin
                            n_bcnt = 8'(q2);
                            n_end  = IW'(q2 - 17'd1);
                            if (32'(r_qty) > MAX_REG_COUNT) begin
                                n_exc = mrs_pkg::EXC_ILLEGAL_DATA;
                            end else if (32'(sq) > ((r_fc == mrs_pkg::FC_RD_HOLDING) ?
                                                    NUM_HOLDING : NUM_INPUT_REGS)) begin
                                n_exc = mrs_pkg::EXC_ILLEGAL_ADDR;
                            end else begin
                                n_kind = mrs_pkg::K_REGS;
                            end
                        end
                        mrs_pkg::FC_WR_COIL: begin
                            coil_wa = AWC'(r_start);
                            coil_wd = (r_qty == mrs_pkg::COIL_ON);
                            if (32'(r_start) >= NUM_COILS) begin
                                n_exc = mrs_pkg::EXC_ILLEGAL_ADDR;
                            end else if (r_qty == mrs_pkg::COIL_ON ||
                                         r_qty == mrs_pkg::COIL_OFF) begin
                                coil_we = 1'b1;
                                n_kind  = mrs_pkg::K_ECHO;
                            end else begin
                                n_exc = mrs_pkg::EXC_ILLEGAL_DATA;
                            end
                        end
                        mrs_pkg::FC_WR_REG: begin
                            hold_wa = AWH'(r_start);
                            hold_wd = r_qty;
                            if (32'(r_start) >= NUM_HOLDING) begin
                                n_exc = mrs_pkg::EXC_ILLEGAL_ADDR;
                            end else begin
                                hold_we = 1'b1;
                                n_kind  = mrs_pkg::K_ECHO;
                            end
                        end
                        mrs_pkg::FC_WR_COILS: begin
                            n_end = IW'(r_qty - 16'd1);
                            if (32'(r_qty) + 16 > MAX_BIT_COUNT || {9'h0, r_bc} != nb) begin
                                n_exc = mrs_pkg::EXC_ILLEGAL_DATA;
                            end else if (32'(sq) > NUM_COILS) begin
                                n_exc = mrs_pkg::EXC_ILLEGAL_ADDR;
                            end else begin
                                n_kind = mrs_pkg::K_ECHO;
                                if (r_qty != 16'h0) begin
                                    n_state = mrs_pkg::S_WR_COILS;
                                end
                            end
                        end
                        mrs_pkg::FC_WR_REGS: begin
                            n_end = IW'(q2 - 17'd1);
                            if (32'(r_qty) + 1 > MAX_REG_COUNT || {9'h0, r_bc} != q2) begin
                                n_exc = mrs_pkg::EXC_ILLEGAL_DATA;
                            end else if (32'(sq) > NUM_HOLDING) begin
                                n_exc = mrs_pkg::EXC_ILLEGAL_ADDR;
                            end else begin
                                n_kind = mrs_pkg::K_ECHO;
                                if (r_qty != 16'h0) begin
                                    n_state = mrs_pkg::S_WR_REGS;
                                end
                            end
                        end
                        mrs_pkg::FC_RD_FIFO: n_exc = mrs_pkg::EXC_ILLEGAL_DATA;
                        default:             n_exc = mrs_pkg::EXC_ILLEGAL_FUNC;
                    endcase
                end
            end
            mrs_pkg::S_WR_COILS: begin
                coil_we = 1'b1;
                coil_wd = fb[r_i[2:0]];
                if (r_i == r_end) begin
                    n_state = mrs_pkg::S_HEAD;
                end else begin
                    n_i  = r_i + IW'(1);
                    n_pa = r_pa + PW'(1);
                    if (r_i[2:0] == 3'd7) begin
                        n_fidx = r_fidx + 7'd1;
                    end
                end
            end
            mrs_pkg::S_WR_REGS: begin
                n_fidx = r_fidx + 7'd1;
                if (!r_i[0]) begin
                    n_acc = fb;
                end else begin
                    hold_we = 1'b1;
                    hold_wd = {r_acc, fb};
                    n_pa    = r_pa + PW'(1);
                end
                if (r_i == r_end) begin
                    n_state = r_bcast ? mrs_pkg::S_STATUS : mrs_pkg::S_HEAD;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            mrs_pkg::S_HEAD: begin
                o_strobe          = 1'b1;
                o_result.has_byte = 1'b1;
                o_result.tx_byte  = head_byte;
                crc_en            = 1'b1;
                crc_data          = head_byte;
                if (r_k == ((r_kind == mrs_pkg::K_ECHO) ? 3'd5 : 3'd2)) begin
                    n_state = mrs_pkg::S_TX_LO;
                    n_pa    = PW'(r_start);
                    n_i     = '0;
                    if (r_kind == mrs_pkg::K_BITS && r_bcnt != 8'h00) begin
                        n_state = mrs_pkg::S_BITS;
                    end else if (r_kind == mrs_pkg::K_REGS && r_bcnt != 8'h00) begin
                        n_state = mrs_pkg::S_REGS;
                    end
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            mrs_pkg::S_BITS: begin
                n_acc = acc_nx;
                if (r_i[2:0] == 3'd7) begin
                    o_strobe          = 1'b1;
                    o_result.has_byte = 1'b1;
                    o_result.tx_byte  = acc_nx;
                    crc_en            = 1'b1;
                    crc_data          = acc_nx;
                end
                if (r_i == r_end) begin
                    n_state = mrs_pkg::S_TX_LO;
                end else begin
                    n_i  = r_i + IW'(1);
                    n_pa = r_pa + PW'(1);
                end
            end
            mrs_pkg::S_REGS: begin
                o_strobe          = 1'b1;
                o_result.has_byte = 1'b1;
                o_result.tx_byte  = r_i[0] ? word_v[7:0] : word_v[15:8];
                crc_en            = 1'b1;
                crc_data          = o_result.tx_byte;
                if (r_i[0]) begin
                    n_pa = r_pa + PW'(1);
                end
                if (r_i == r_end) begin
                    n_state = mrs_pkg::S_TX_LO;
                end else begin
                    n_i = r_i + IW'(1);
                end
            end
            mrs_pkg::S_TX_LO: begin
                o_strobe          = 1'b1;
                o_result.has_byte = 1'b1;
                o_result.tx_byte  = crc[7:0];
                n_state           = mrs_pkg::S_TX_HI;
            end
            mrs_pkg::S_TX_HI: begin
                o_strobe          = 1'b1;
                o_result.has_byte = 1'b1;
                o_result.tx_byte  = crc[15:8];
                o_result.last     = 1'b1;
                n_state           = mrs_pkg::S_IDLE;
            end
            mrs_pkg::S_STATUS: begin
                o_strobe              = 1'b1;
                o_result.last         = 1'b1;
                o_result.frame_status = r_status;
                n_state               = mrs_pkg::S_IDLE;
            end
            default: n_state = mrs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrs_pkg::S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= 7'd0;
            r_slave <= 8'd1;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cnt   <= n_cnt;
            if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
                r_slave <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_n      <= n_n;
        r_fidx   <= n_fidx;
        r_a      <= n_a;
        r_fc     <= n_fc;
        r_start  <= n_start;
        r_qty    <= n_qty;
        r_bc     <= n_bc;
        r_exc    <= n_exc;
        r_bcast  <= n_bcast;
        r_status <= n_status;
        r_k      <= n_k;
        r_i      <= n_i;
        r_end    <= n_end;
        r_pa     <= n_pa;
        r_acc    <= n_acc;
        r_bcnt   <= n_bcnt;
    end

    // Stores: one write and one registered read per cycle; the read address is the
    // next value of the pointer so that data lines up with the pointer register.
    always_ff @(posedge i_clk) begin
        if (frame_we) begin
            frame_mem[r_cnt[5:0]] <= i_item.rx_byte;
        end
        r_frd <= frame_mem[n_fidx[5:0]];
    end

    always_ff @(posedge i_clk) begin
        if (coil_we) begin
            coil_mem[coil_wa] <= coil_wd;
        end
        r_coil_rd <= coil_mem[AWC'(n_pa)];
    end

    always_ff @(posedge i_clk) begin
        if (disc_we) begin
            disc_mem[disc_wa] <= disc_wd;
        end
        r_disc_rd <= disc_mem[AWD'(n_pa)];
    end

    always_ff @(posedge i_clk) begin
        if (hold_we) begin
            hold_mem[hold_wa] <= hold_wd;
        end
        r_hold_rd <= hold_mem[AWH'(n_pa)];
    end

    always_ff @(posedge i_clk) begin
        if (inp_we) begin
            inp_mem[inp_wa] <= inp_wd;
        end
        r_inp_rd <= inp_mem[AWI'(n_pa)];
    end

endmodule

@@ src/mrs_checker.sv @@
// Port-level checks for the Modbus RTU slave engine, bound to the top level.
// Depends on mrs_pkg and modbus_rtu_slave_engine_defines.svh.
`include "modbus_rtu_slave_engine_defines.svh"

module mrs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               busy,
    input logic               o_strobe,
    input mrs_pkg::t_out_item o_result
);

    `MRS_ASSERT_ALWAYS(a_reset_busy, i_clk, !i_rst_n |=> busy && !o_strobe, "not busy after reset")
    `MRS_ASSERT_CLK(a_strobe_busy, i_clk, i_rst_n, o_strobe |-> busy, "result while idle")
    `MRS_ASSERT_CLK(a_last_idle, i_clk, i_rst_n, o_strobe && o_result.last |=> !busy, "still busy after the last transfer")
    `MRS_ASSERT_CLK(a_no_byte, i_clk, i_rst_n, o_strobe && !o_result.has_byte |-> o_result.last && o_result.frame_status != mrs_pkg::ST_REPLY, "status result malformed")

endmodule

bind modbus_rtu_slave_engine mrs_checker u_mrs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
